// ----- design/fla_pkg.sv -----
// Shared types, constants and helpers for the free-list allocator.
`timescale 1ns / 1ps
package fla_pkg;

  localparam int MAX_SEGMENTS    = 64;
  localparam int MAX_LIVE        = 64;
  localparam int MIN_BLOCK_BYTES = 16;
  localparam int HEADER_BYTES    = 16;

  localparam int SEG_AW  = $clog2(MAX_SEGMENTS);
  localparam int SEG_CW  = $clog2(MAX_SEGMENTS + 1);
  localparam int LIVE_AW = $clog2(MAX_LIVE);
  localparam int LIVE_CW = $clog2(MAX_LIVE + 1);

  localparam logic [20:0] POOL_MIN = 21'd16;
  localparam logic [20:0] POOL_MAX = 21'd1048576;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_RESET = 2'd2,
    OP_BAD   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_FIT   = 3'd1,
    ST_BAD_REQ  = 3'd2,
    ST_UNKNOWN  = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    CFG_FIT_POLICY = 1'b0,
    CFG_POOL_SIZE  = 1'b1
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_AFREE, S_ARD, S_AEV, S_APPLY,
    S_SHRD, S_SHWR, S_FRD, S_FEV, S_FPRD, S_FPEV, S_FJOIN,
    S_UPRD, S_UPWR, S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [20:0] req_size;
    logic [12:0] alignment;
    logic [20:0] user_offset;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [20:0] granted_offset;
    logic [20:0] granted_size;
    logic [12:0] granted_padding;
  } rsp_t;

  typedef struct packed {
    logic [20:0] start;
    logic [20:0] len;
  } seg_t;

  typedef struct packed {
    logic [20:0] off;
    logic [20:0] len;
    logic [12:0] pad;
  } rec_t;

  // Padding from a block start to an aligned user address with header room.
  function automatic logic [12:0] pad_for(logic [20:0] start, logic [12:0] align);
    logic [12:0] pad0;
    pad0 = (13'd0 - start[12:0]) & (align - 13'd1);
    if (align <= 13'(HEADER_BYTES)) pad_for = pad0 + 13'(HEADER_BYTES);
    else if (pad0 < 13'(HEADER_BYTES)) pad_for = pad0 + align;
    else pad_for = pad0;
  endfunction

endpackage

// ----- design/free_list_allocator_unit.sv -----
// Top level of the free-list allocator: sequencer over segment and record tables.
//
//  channel | signals                          | dir | beat
//  req     | req_valid req_ready req          | in  | one request
//  rsp     | rsp_valid rsp_ready rsp          | out | one result
//  cfg     | cfg_valid cfg_ready cfg_index    | in  | one register write
//          | cfg_data                         |     |
//
// Steps: an allocate visits each occupied record slot ahead of the first free
// one; a free visits each empty slot and reads and checks each live record. Both
// then read and evaluate each segment scanned, and read and write each segment
// moved, besides the accept and done states. Each table has a single read port,
// so every entry is read before it is used. After rst the init state writes the
// pool as one segment before req_ready rises; a pool reset passes init and done.
// req_ready is high only in idle; a result waits in the output register while
// the next request is accepted. cfg_ready is always high.
`timescale 1ns / 1ps
module free_list_allocator_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  fla_pkg::req_t    req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output fla_pkg::rsp_t    rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [20:0]      cfg_data
);

  localparam int SAW = fla_pkg::SEG_AW;
  localparam int SCW = fla_pkg::SEG_CW;
  localparam int LAW = fla_pkg::LIVE_AW;
  localparam int LCW = fla_pkg::LIVE_CW;

  fla_pkg::state_t state, state_next;
  logic            policy;
  logic [20:0]     pool;
  logic [SCW-1:0]  count, count_next;
  logic [fla_pkg::MAX_LIVE-1:0] valid, valid_next;
  logic            init_only, init_only_next;

  // payload registers
  logic [LCW-1:0]  idx, idx_next;
  logic [LAW-1:0]  slot, slot_next;
  logic            found, found_next;
  logic [SAW-1:0]  best, best_next;
  logic [12:0]     bpad, bpad_next;
  logic [20:0]     bdiff, bdiff_next;
  logic [20:0]     bstart, bstart_next;
  logic [20:0]     blen, blen_next;
  logic [20:0]     size, size_next;
  logic [12:0]     align, align_next;
  logic [20:0]     uoff, uoff_next;
  logic [20:0]     prev_start, prev_start_next;
  logic [20:0]     prev_len, prev_len_next;
  logic [21:0]     prev_end, prev_end_next;
  logic            have_prev, have_prev_next;
  logic            have_next, have_next_next;
  logic [20:0]     nxt_start, nxt_start_next;
  logic [20:0]     nxt_len, nxt_len_next;
  fla_pkg::rsp_t   res, res_next;
  logic            rsp_valid_next;
  fla_pkg::rsp_t   rsp_next;

  // table ports
  logic            seg_we, rec_we;
  logic [SAW-1:0]  seg_waddr, seg_raddr;
  logic [LAW-1:0]  rec_waddr, rec_raddr;
  fla_pkg::seg_t   seg_wdata, seg_rdata;
  fla_pkg::rec_t   rec_wdata, rec_rdata;

  // combinational helpers
  logic [20:0]     pool_sat;
  logic [12:0]     cur_pad;
  logic [21:0]     cur_need;
  logic [20:0]     cur_diff;
  logic [21:0]     a_need;
  logic [21:0]     b_end;
  logic            jn, jp;
  logic [SAW-1:0]  pm1;
  logic [SCW-1:0]  i_p1;

  fla_ram #(.WIDTH($bits(fla_pkg::seg_t)), .DEPTH(fla_pkg::MAX_SEGMENTS)) u_seg (
    .clk(clk), .we(seg_we), .waddr(seg_waddr), .wdata(seg_wdata),
    .raddr(seg_raddr), .rdata(seg_rdata)
  );

  fla_ram #(.WIDTH($bits(fla_pkg::rec_t)), .DEPTH(fla_pkg::MAX_LIVE)) u_rec (
    .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
    .raddr(rec_raddr), .rdata(rec_rdata)
  );

  assign cfg_ready = 1'b1;
  assign req_ready = (state == fla_pkg::S_IDLE);

  // saturated pool size for a pool reset
  always_comb begin
    if (pool < fla_pkg::POOL_MIN) pool_sat = fla_pkg::POOL_MIN;
    else if (pool > fla_pkg::POOL_MAX) pool_sat = fla_pkg::POOL_MAX;
    else pool_sat = pool;
  end

  // fit arithmetic on the segment just read
  assign cur_pad  = fla_pkg::pad_for(seg_rdata.start, align);
  assign cur_need = 22'(cur_pad) + 22'(size);
  assign cur_diff = 21'(22'(seg_rdata.len) - cur_need);
  assign a_need   = 22'(bpad) + 22'(size);
  assign b_end    = 22'(bstart) + 22'(blen);
  assign jn       = have_next && (b_end == 22'(nxt_start));
  assign jp       = have_prev && (prev_end == 22'(bstart));
  assign pm1      = SAW'(idx - LCW'(1));
  assign i_p1     = SCW'(idx) + SCW'(1);

  // sequencer
  always_comb begin
    state_next      = state;
    count_next      = count;
    valid_next      = valid;
    init_only_next  = init_only;
    idx_next        = idx;
    slot_next       = slot;
    found_next      = found;
    best_next       = best;
    bpad_next       = bpad;
    bdiff_next      = bdiff;
    bstart_next     = bstart;
    blen_next       = blen;
    size_next       = size;
    align_next      = align;
    uoff_next       = uoff;
    prev_start_next = prev_start;
    prev_len_next   = prev_len;
    prev_end_next   = prev_end;
    have_prev_next  = have_prev;
    have_next_next  = have_next;
    nxt_start_next  = nxt_start;
    nxt_len_next    = nxt_len;
    res_next        = res;
    seg_we          = 1'b0;
    seg_waddr       = '0;
    seg_wdata       = '0;
    seg_raddr       = SAW'(idx);
    rec_we          = 1'b0;
    rec_waddr       = slot;
    rec_wdata       = '0;
    rec_raddr       = LAW'(idx);
    rsp_valid_next  = rsp_valid && !rsp_ready;
    rsp_next        = rsp;

    unique case (state)
      fla_pkg::S_INIT: begin
        seg_we     = 1'b1;
        seg_waddr  = '0;
        seg_wdata  = '{start: 21'd0, len: pool_sat};
        count_next = SCW'(1);
        valid_next = '0;
        res_next   = '0;
        state_next = init_only ? fla_pkg::S_IDLE : fla_pkg::S_DONE;
      end

      fla_pkg::S_IDLE: begin
        if (req_valid) begin
          size_next  = (req.req_size < 21'(fla_pkg::MIN_BLOCK_BYTES)) ?
                       21'(fla_pkg::MIN_BLOCK_BYTES) : req.req_size;
          align_next = req.alignment;
          uoff_next  = req.user_offset;
          idx_next   = '0;
          found_next = 1'b0;
          res_next   = '0;
          state_next = fla_pkg::S_DONE;
          case (req.opcode)
            fla_pkg::OP_ALLOC: begin
              if (req.req_size == 21'd0 || req.alignment == 13'd0 ||
                  (req.alignment & (req.alignment - 13'd1)) != 13'd0)
                res_next.status = fla_pkg::ST_BAD_REQ;
              else state_next = fla_pkg::S_AFREE;
            end
            fla_pkg::OP_FREE: begin
              if (req.user_offset != 21'd0) state_next = fla_pkg::S_FRD;
            end
            fla_pkg::OP_RESET: begin
              init_only_next = 1'b0;
              state_next     = fla_pkg::S_INIT;
            end
            default: res_next.status = fla_pkg::ST_BAD_REQ;
          endcase
        end
      end

      // first free record slot
      fla_pkg::S_AFREE: begin
        if (idx == LCW'(fla_pkg::MAX_LIVE)) begin
          res_next.status = fla_pkg::ST_FULL;
          state_next      = fla_pkg::S_DONE;
        end else if (!valid[LAW'(idx)]) begin
          slot_next  = LAW'(idx);
          idx_next   = '0;
          state_next = fla_pkg::S_ARD;
        end else idx_next = idx + LCW'(1);
      end

      // segment search
      fla_pkg::S_ARD: begin
        if (SCW'(idx) == count) begin
          if (found) state_next = fla_pkg::S_APPLY;
          else begin
            res_next.status = fla_pkg::ST_NO_FIT;
            state_next      = fla_pkg::S_DONE;
          end
        end else state_next = fla_pkg::S_AEV;
      end

      fla_pkg::S_AEV: begin
        state_next = fla_pkg::S_ARD;
        idx_next   = idx + LCW'(1);
        if (22'(seg_rdata.len) >= cur_need && (!found || cur_diff < bdiff)) begin
          found_next  = 1'b1;
          best_next   = SAW'(idx);
          bpad_next   = cur_pad;
          bdiff_next  = cur_diff;
          bstart_next = seg_rdata.start;
          blen_next   = seg_rdata.len;
          if (!policy || cur_diff == 21'd0) state_next = fla_pkg::S_APPLY;
        end
      end

      fla_pkg::S_APPLY: begin
        rec_we                   = 1'b1;
        rec_waddr                = slot;
        valid_next[slot]         = 1'b1;
        res_next.status          = fla_pkg::ST_OK;
        res_next.granted_offset  = bstart + 21'(bpad);
        res_next.granted_padding = bpad;
        if (bdiff >= 21'(fla_pkg::MIN_BLOCK_BYTES)) begin
          seg_we                = 1'b1;
          seg_waddr             = best;
          seg_wdata             = '{start: 21'(22'(bstart) + a_need), len: bdiff};
          rec_wdata             = '{off: bstart + 21'(bpad), len: 21'(a_need), pad: bpad};
          res_next.granted_size = 21'(a_need);
          state_next            = fla_pkg::S_DONE;
        end else begin
          rec_wdata             = '{off: bstart + 21'(bpad), len: blen, pad: bpad};
          res_next.granted_size = blen;
          idx_next              = LCW'(best);
          state_next            = fla_pkg::S_SHRD;
        end
      end

      // close a gap: move entries down by one
      fla_pkg::S_SHRD: begin
        seg_raddr = SAW'(i_p1);
        if (i_p1 < count) state_next = fla_pkg::S_SHWR;
        else begin
          count_next = count - SCW'(1);
          state_next = fla_pkg::S_DONE;
        end
      end

      fla_pkg::S_SHWR: begin
        seg_we     = 1'b1;
        seg_waddr  = SAW'(idx);
        seg_wdata  = seg_rdata;
        idx_next   = idx + LCW'(1);
        state_next = fla_pkg::S_SHRD;
      end

      // record lookup for free
      fla_pkg::S_FRD: begin
        if (idx == LCW'(fla_pkg::MAX_LIVE)) begin
          res_next.status = fla_pkg::ST_UNKNOWN;
          state_next      = fla_pkg::S_DONE;
        end else if (valid[LAW'(idx)]) state_next = fla_pkg::S_FEV;
        else idx_next = idx + LCW'(1);
      end

      fla_pkg::S_FEV: begin
        if (rec_rdata.off == uoff) begin
          slot_next      = LAW'(idx);
          bstart_next    = rec_rdata.off - 21'(rec_rdata.pad);
          blen_next      = rec_rdata.len;
          idx_next       = '0;
          have_prev_next = 1'b0;
          have_next_next = 1'b0;
          state_next     = fla_pkg::S_FPRD;
        end else begin
          idx_next   = idx + LCW'(1);
          state_next = fla_pkg::S_FRD;
        end
      end

      // insertion point search
      fla_pkg::S_FPRD: begin
        if (SCW'(idx) == count) state_next = fla_pkg::S_FJOIN;
        else state_next = fla_pkg::S_FPEV;
      end

      fla_pkg::S_FPEV: begin
        if (seg_rdata.start < bstart) begin
          prev_start_next = seg_rdata.start;
          prev_len_next   = seg_rdata.len;
          prev_end_next   = 22'(seg_rdata.start) + 22'(seg_rdata.len);
          have_prev_next  = 1'b1;
          idx_next        = idx + LCW'(1);
          state_next      = fla_pkg::S_FPRD;
        end else begin
          nxt_start_next = seg_rdata.start;
          nxt_len_next   = seg_rdata.len;
          have_next_next = 1'b1;
          state_next     = fla_pkg::S_FJOIN;
        end
      end

      fla_pkg::S_FJOIN: begin
        res_next.granted_size = blen;
        if (jp || jn) begin
          valid_next[slot] = 1'b0;
          seg_we           = 1'b1;
          state_next       = fla_pkg::S_DONE;
          if (jp && jn) begin
            seg_waddr  = pm1;
            seg_wdata  = '{start: prev_start, len: prev_len + blen + nxt_len};
            state_next = fla_pkg::S_SHRD;
          end else if (jp) begin
            seg_waddr = pm1;
            seg_wdata = '{start: prev_start, len: prev_len + blen};
          end else begin
            seg_waddr = SAW'(idx);
            seg_wdata = '{start: bstart, len: nxt_len + blen};
          end
        end else if (count >= SCW'(fla_pkg::MAX_SEGMENTS)) begin
          res_next        = '0;
          res_next.status = fla_pkg::ST_FULL;
          state_next      = fla_pkg::S_DONE;
        end else begin
          best_next  = SAW'(idx);
          idx_next   = LCW'(count);
          state_next = fla_pkg::S_UPRD;
        end
      end

      // open a gap: move entries up by one, then insert
      fla_pkg::S_UPRD: begin
        seg_raddr = pm1;
        if (SAW'(idx) != best || SCW'(idx) > SCW'(best)) begin
          state_next = fla_pkg::S_UPWR;
        end else begin
          seg_we           = 1'b1;
          seg_waddr        = best;
          seg_wdata        = '{start: bstart, len: blen};
          count_next       = count + SCW'(1);
          valid_next[slot] = 1'b0;
          state_next       = fla_pkg::S_DONE;
        end
      end

      fla_pkg::S_UPWR: begin
        seg_we     = 1'b1;
        seg_waddr  = SAW'(idx);
        seg_wdata  = seg_rdata;
        idx_next   = idx - LCW'(1);
        state_next = fla_pkg::S_UPRD;
      end

      fla_pkg::S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_valid_next = 1'b1;
          rsp_next       = res;
          state_next     = fla_pkg::S_IDLE;
        end
      end

      default: state_next = fla_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fla_pkg::S_INIT;
      init_only <= 1'b1;
      policy    <= 1'b0;
      pool      <= fla_pkg::POOL_MAX;
      count     <= SCW'(1);
      valid     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      init_only <= (state == fla_pkg::S_INIT) ? 1'b1 : init_only_next;
      count     <= count_next;
      valid     <= valid_next;
      rsp_valid <= rsp_valid_next;
      if (cfg_valid) begin
        unique case (cfg_index)
          fla_pkg::CFG_FIT_POLICY: policy <= cfg_data[0];
          fla_pkg::CFG_POOL_SIZE:  pool   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    slot       <= slot_next;
    found      <= found_next;
    best       <= best_next;
    bpad       <= bpad_next;
    bdiff      <= bdiff_next;
    bstart     <= bstart_next;
    blen       <= blen_next;
    size       <= size_next;
    align      <= align_next;
    uoff       <= uoff_next;
    prev_start <= prev_start_next;
    prev_len   <= prev_len_next;
    prev_end   <= prev_end_next;
    have_prev  <= have_prev_next;
    have_next  <= have_next_next;
    nxt_start  <= nxt_start_next;
    nxt_len    <= nxt_len_next;
    res        <= res_next;
    rsp        <= rsp_next;
  end

endmodule

// ----- design/fla_ram.sv -----
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module fla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- design/fla_checker.sv -----
// Port-level checks for the free-list allocator, bound to the top level.
`timescale 1ns / 1ps
module fla_checker (
  input logic          clk,
  input logic          rst,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input fla_pkg::rsp_t rsp
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // status code in range
  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status <= 3'd4)
    else $error("status out of range");

  // failed requests carry zero fields
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != fla_pkg::ST_OK |->
      rsp.granted_offset == 21'd0 && rsp.granted_size == 21'd0 &&
      rsp.granted_padding == 13'd0)
    else $error("nonzero fields on failed request");

  // a grant always leaves header room
  a_grant: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == fla_pkg::ST_OK && rsp.granted_offset != 21'd0 |->
      rsp.granted_padding >= 13'(fla_pkg::HEADER_BYTES) &&
      rsp.granted_size >= 21'(fla_pkg::MIN_BLOCK_BYTES))
    else $error("grant without header room");

endmodule

bind free_list_allocator_unit fla_checker u_fla_checker (
  .clk(clk), .rst(rst), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
);

// ----- tb/free_list_allocator_unit_test.sv -----
// Self-checking bench for the free-list allocator: random and directed requests vs a predictor.
`timescale 1ns / 1ps
module free_list_allocator_unit_test;
  import fla_pkg::*;

  // Scoreboard: pool bookkeeping copy and queue of pending results
  class alloc_scoreboard;
    bit          policy_best;
    logic [20:0] pool_bytes;
    logic [20:0] seg_base[MAX_SEGMENTS];
    logic [20:0] seg_len[MAX_SEGMENTS];
    int          seg_num;
    logic [20:0] rec_off[MAX_LIVE];
    logic [20:0] rec_len[MAX_LIVE];
    logic [12:0] rec_pad[MAX_LIVE];
    bit          rec_live[MAX_LIVE];
    rsp_t        pending[$];
    int          errors;
    int          n_ok, n_nofit, n_full, n_unknown, n_bad;

    function new();
      policy_best = 0;
      pool_bytes = POOL_MAX;
      errors = 0;
      clear_pool();
    endfunction

    function void clear_pool();
      logic [20:0] sz;
      sz = pool_bytes;
      if (sz < POOL_MIN) sz = POOL_MIN;
      if (sz > POOL_MAX) sz = POOL_MAX;
      seg_base[0] = 0;
      seg_len[0] = sz;
      seg_num = 1;
      for (int k = 0; k < MAX_LIVE; k++) rec_live[k] = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [20:0] val);
      if (idx == CFG_FIT_POLICY) policy_best = val[0];
      else pool_bytes = val;
    endfunction

    function int unsigned header_pad(int unsigned start, int unsigned align);
      int unsigned p;
      p = (align - (start & (align - 1))) & (align - 1);
      if (p < HEADER_BYTES) p += align * ((HEADER_BYTES - p + align - 1) / align);
      return p;
    endfunction

    function rsp_t grant(int unsigned size, int unsigned align);
      rsp_t r;
      int slot, hit;
      int unsigned p, need, diff, hit_pad, hit_diff, base;
      r = '0;
      if (size == 0 || align == 0 || (align & (align - 1)) != 0) begin
        r.status = ST_BAD_REQ;
        return r;
      end
      if (size < MIN_BLOCK_BYTES) size = MIN_BLOCK_BYTES;
      slot = -1;
      for (int k = 0; k < MAX_LIVE; k++)
        if (!rec_live[k]) begin slot = k; break; end
      if (slot < 0) begin
        r.status = ST_FULL;
        return r;
      end
      hit = -1;
      for (int k = 0; k < seg_num; k++) begin
        p = header_pad(seg_base[k], align);
        need = p + size;
        if (seg_len[k] >= need) begin
          diff = seg_len[k] - need;
          if (hit < 0 || diff < hit_diff) begin
            hit = k; hit_pad = p; hit_diff = diff;
            if (!policy_best || diff == 0) break;
          end
        end
      end
      if (hit < 0) begin
        r.status = ST_NO_FIT;
        return r;
      end
      need = hit_pad + size;
      base = seg_base[hit];
      if (seg_len[hit] - need >= MIN_BLOCK_BYTES) begin
        seg_base[hit] = base + need;
        seg_len[hit] = seg_len[hit] - need;
      end else begin
        // small leftover goes with the block
        need = seg_len[hit];
        for (int k = hit; k + 1 < seg_num; k++) begin
          seg_base[k] = seg_base[k+1];
          seg_len[k] = seg_len[k+1];
        end
        seg_num--;
      end
      rec_off[slot] = base + hit_pad;
      rec_len[slot] = need;
      rec_pad[slot] = hit_pad;
      rec_live[slot] = 1;
      r.status = ST_OK;
      r.granted_offset = base + hit_pad;
      r.granted_size = need;
      r.granted_padding = hit_pad;
      return r;
    endfunction

    function rsp_t release_block(logic [20:0] uoff);
      rsp_t r;
      int slot, p;
      int unsigned bstart, blen;
      bit jn, jp;
      r = '0;
      if (uoff == 0) return r;
      slot = -1;
      for (int k = 0; k < MAX_LIVE; k++)
        if (rec_live[k] && rec_off[k] == uoff) begin slot = k; break; end
      if (slot < 0) begin
        r.status = ST_UNKNOWN;
        return r;
      end
      bstart = rec_off[slot] - rec_pad[slot];
      blen = rec_len[slot];
      p = 0;
      while (p < seg_num && seg_base[p] < bstart) p++;
      jn = p < seg_num && bstart + blen == seg_base[p];
      jp = p > 0 && seg_base[p-1] + seg_len[p-1] == bstart;
      if (jp && jn) begin
        seg_len[p-1] = seg_len[p-1] + blen + seg_len[p];
        for (int k = p; k + 1 < seg_num; k++) begin
          seg_base[k] = seg_base[k+1];
          seg_len[k] = seg_len[k+1];
        end
        seg_num--;
      end else if (jp) begin
        seg_len[p-1] = seg_len[p-1] + blen;
      end else if (jn) begin
        seg_base[p] = bstart;
        seg_len[p] = seg_len[p] + blen;
      end else begin
        if (seg_num >= MAX_SEGMENTS) begin
          r.status = ST_FULL;
          return r;
        end
        for (int k = seg_num; k > p; k--) begin
          seg_base[k] = seg_base[k-1];
          seg_len[k] = seg_len[k-1];
        end
        seg_base[p] = bstart;
        seg_len[p] = blen;
        seg_num++;
      end
      rec_live[slot] = 0;
      r.status = ST_OK;
      r.granted_size = blen;
      return r;
    endfunction

    // Predict the result of one accepted request beat
    function void note_request(req_t q);
      rsp_t r;
      r = '0;
      case (opcode_t'(q.opcode))
        OP_ALLOC: r = grant(q.req_size, q.alignment);
        OP_FREE:  r = release_block(q.user_offset);
        OP_RESET: clear_pool();
        default:  r.status = ST_BAD_REQ;
      endcase
      case (status_t'(r.status))
        ST_OK:      n_ok++;
        ST_NO_FIT:  n_nofit++;
        ST_FULL:    n_full++;
        ST_UNKNOWN: n_unknown++;
        default:    n_bad++;
      endcase
      pending.push_back(r);
    endfunction

    // Compare one result beat against the oldest prediction
    function void check_result(rsp_t got);
      rsp_t exp_r;
      if (pending.size() == 0) begin
        $error("result with nothing pending: %h", got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.status !== exp_r.status) begin
        $error("status exp %0d got %0d", exp_r.status, got.status);
        errors++;
      end
      if (got.granted_offset !== exp_r.granted_offset) begin
        $error("granted_offset exp %0d got %0d", exp_r.granted_offset, got.granted_offset);
        errors++;
      end
      if (got.granted_size !== exp_r.granted_size) begin
        $error("granted_size exp %0d got %0d", exp_r.granted_size, got.granted_size);
        errors++;
      end
      if (got.granted_padding !== exp_r.granted_padding) begin
        $error("granted_padding exp %0d got %0d", exp_r.granted_padding,
               got.granted_padding);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_ready;
  rsp_t        rsp;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [20:0] cfg_data;

  alloc_scoreboard sb;
  logic [20:0] live_offs[$];
  int          cycles;
  int          n_sent;

  free_list_allocator_unit dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 2000000) begin
        $display("timeout after %0d cycles", cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Result side: random stall per beat, sample at the rising edge
  initial begin
    int gap;
    rsp_ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if ($urandom_range(0, 5) == 0) gap = 0;
      repeat (gap) @(negedge clk);
      rsp_ready = 1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      sb.check_result(rsp);
      @(negedge clk);
      rsp_ready = 0;
    end
  end

  task automatic send(opcode_t op, logic [20:0] size, logic [12:0] align,
                      logic [20:0] uoff);
    int gap;
    gap = (n_sent % 200 < 40) ? 0 : $urandom_range(0, 10);
    repeat (gap) @(negedge clk);
    req_valid = 1;
    req = '{opcode: op, req_size: size, alignment: align, user_offset: uoff};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_request(req);
    if (op == OP_ALLOC && sb.pending[$].status == ST_OK)
      live_offs.push_back(sb.pending[$].granted_offset);
    if (op == OP_FREE && sb.pending[$].status == ST_OK && uoff != 0)
      foreach (live_offs[k]) if (live_offs[k] == uoff) begin
        live_offs.delete(k);
        break;
      end
    if (op == OP_RESET) live_offs.delete();
    n_sent++;
    @(negedge clk);
    req_valid = 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [20:0] val);
    drain();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic [12:0] rand_align();
    return 13'(1) << $urandom_range(0, 12);
  endfunction

  function automatic logic [20:0] rand_size();
    case ($urandom_range(0, 9))
      0:       return 21'($urandom_range(1, 15));
      1:       return 21'($urandom_range(1, 1048576));
      2:       return 21'($urandom_range(4096, 65536));
      default: return 21'($urandom_range(16, 2048));
    endcase
  endfunction

  // One random request, mostly alloc/free of live blocks
  task automatic random_item();
    int pick;
    logic [20:0] r21;
    pick = $urandom_range(0, 99);
    r21 = 21'($urandom);
    if (pick < 48) send(OP_ALLOC, rand_size(), rand_align(), r21);
    else if (pick < 88 && live_offs.size() != 0)
      send(OP_FREE, r21, 13'($urandom),
           live_offs[$urandom_range(0, live_offs.size() - 1)]);
    else if (pick < 92)
      send(OP_FREE, r21, 13'($urandom), 21'($urandom_range(0, 1048576)));
    else if (pick < 94) send(OP_ALLOC, r21, 13'($urandom), r21);
    else if (pick < 96) send(OP_BAD, r21, 13'($urandom), r21);
    else if (pick < 97) send(OP_RESET, r21, 13'($urandom), r21);
    else send(OP_ALLOC, rand_size(), rand_align(), r21);
  endtask

  initial begin
    sb = new();
    n_sent = 0;
    rst = 1;
    req_valid = 0;
    req = '0;
    cfg_valid = 0;
    cfg_index = CFG_FIT_POLICY;
    cfg_data = '0;
    repeat (8) @(negedge clk);
    rst = 0;

    // Directed: field extremes, bad requests, null/unknown free
    send(OP_ALLOC, 21'd1048576, 13'd4096, 21'h1FFFFF);
    send(OP_ALLOC, 21'd1, 13'd1, '0);
    send(OP_ALLOC, 21'd0, 13'd8, '0);
    send(OP_ALLOC, 21'd32, 13'd0, '0);
    send(OP_ALLOC, 21'd32, 13'd12, '0);
    send(OP_ALLOC, 21'h1FFFFF, 13'h1FFF, '0);
    send(OP_FREE, '0, '0, 21'd0);
    send(OP_FREE, '0, '0, 21'd12345);
    send(OP_FREE, '0, '0, 21'h1FFFFF);
    send(OP_BAD, 21'h1FFFFF, 13'h1FFF, 21'h1FFFFF);
    send(OP_RESET, '0, '0, '0);
    send(OP_ALLOC, 21'd1048560, 13'd16, '0);
    send(OP_ALLOC, 21'd16, 13'd16, '0);
    send(OP_RESET, '0, '0, '0);
    send(OP_FREE, '0, '0, live_offs.size() ? live_offs[0] : 21'd32);

    // Record table full, then scattered frees and a merge on both sides
    write_reg(CFG_POOL_SIZE, 21'd65536);
    send(OP_RESET, '0, '0, '0);
    for (int k = 0; k < 66; k++) send(OP_ALLOC, 21'd16, 13'd16, '0);
    for (int k = 0; k < 64; k += 2) send(OP_FREE, '0, '0, 21'd16 + 21'(k * 32));
    send(OP_FREE, '0, '0, 21'd16 + 21'd64 * 32 - 21'd32);

    // Smallest pool, saturated pool sizes
    write_reg(CFG_POOL_SIZE, 21'd0);
    send(OP_RESET, '0, '0, '0);
    send(OP_ALLOC, 21'd1, 13'd1, '0);
    write_reg(CFG_POOL_SIZE, 21'h1FFFFF);
    send(OP_RESET, '0, '0, '0);

    // Random phases through several settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_FIT_POLICY, 21'(ph[0]));
      case (ph)
        0: write_reg(CFG_POOL_SIZE, 21'd1048576);
        1: write_reg(CFG_POOL_SIZE, 21'd16);
        2: write_reg(CFG_POOL_SIZE, 21'd8192);
        default: write_reg(CFG_POOL_SIZE, 21'($urandom_range(16, 1048576)));
      endcase
      send(OP_RESET, '0, '0, '0);
      live_offs.delete();
      for (int k = 0; k < 165; k++) begin
        random_item();
        if (k == 82) drain();
      end
    end

    drain();
    $display("sent %0d requests: %0d ok, %0d no-fit, %0d full, %0d unknown, %0d bad",
             n_sent, sb.n_ok, sb.n_nofit, sb.n_full, sb.n_unknown, sb.n_bad);
    $display("covered both fit policies, pool sizes 16 to 1 MiB, merges and table limits");
    if (sb.errors == 0 && sb.pending.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
